FILE: rtl/core/clms_pkg.sv
// Shared types, register indexes and reset constants of the coded lock motor sequencer.
// No dependencies; clms_cfg, clms_core and the top level import this package.
`timescale 1ns / 1ps

package clms_pkg;

    // Number of code bytes sent before an open rotation (1 to 4).
    localparam int CLMS_CODE_BYTES = 3;

    // Configuration port geometry.
    localparam int CLMS_IDX_W  = 4;
    localparam int CLMS_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CLMS_IDX_W-1:0] {
        REG_CODE_HEAD    = 4'd0,
        REG_CODE_ADDRESS = 4'd1,
        REG_CODE_OPEN    = 4'd2,
        REG_BLIND_TICKS  = 4'd3,
        REG_TIMEOUT      = 4'd4,
        REG_ONE_WIDTH    = 4'd5,
        REG_ZERO_WIDTH   = 4'd6,
        REG_GAP_WIDTH    = 4'd7
    } t_reg_idx;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_CODE_BYTE = 8'h00;
    localparam logic [15:0] RST_BLIND     = 16'd2000;
    localparam logic [15:0] RST_TIMEOUT   = 16'd5000;
    localparam logic [7:0]  RST_ONE       = 8'd10;
    localparam logic [7:0]  RST_ZERO      = 8'd4;
    localparam logic [7:0]  RST_GAP       = 8'd4;

    // Speech request codes.
    localparam logic [1:0] ANN_NONE   = 2'd0;
    localparam logic [1:0] ANN_OPENED = 2'd1;
    localparam logic [1:0] ANN_CLOSED = 2'd2;

    // Configuration write request.
    typedef struct packed {
        logic [CLMS_IDX_W-1:0]  index;
        logic [CLMS_DATA_W-1:0] wdata;
    } t_cfg_req;

    // Configuration register set as seen by the sequencer.
    typedef struct packed {
        logic [7:0]  code_head;
        logic [7:0]  code_address;
        logic [7:0]  code_open;
        logic [15:0] blind_ticks;
        logic [15:0] timeout_ticks;
        logic [7:0]  one_width;
        logic [7:0]  zero_width;
        logic [7:0]  gap_width;
    } t_cfg;

    // One tick request.
    typedef struct packed {
        logic        key_on;
        logic        id_ok;
        logic        auto_close;
        logic        overcurrent;
        logic        silent;
        logic [15:0] battery_sample;
    } t_in;

    // One tick result.
    typedef struct packed {
        logic        motor_a;
        logic        motor_b;
        logic        block_buttons;
        logic        force_power_off;
        logic        lock_open;
        logic        open_done;
        logic        close_done;
        logic [1:0]  announce;
        logic [15:0] battery_latched;
    } t_out;

endpackage

FILE: rtl/core/clms_stream_if.sv
// Valid/ready channel interface used for the tick, result and configuration channels.
// The payload type is a parameter; the block uses the structs of clms_pkg.
`timescale 1ns / 1ps

interface clms_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/clms_cfg.sv
// Configuration register file of the coded lock motor sequencer.
// Depends on clms_pkg and clms_stream_if; always ready, one write per cycle.
`timescale 1ns / 1ps

module clms_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    clms_stream_if.sink   i_cfg,
    output clms_pkg::t_cfg o_cfg,
    output logic          o_code_wr
);
    import clms_pkg::*;

    t_cfg r_cfg;
    logic r_code_wr;
    logic w_wr;

    // Writes are never stalled.
    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_head     <= RST_CODE_BYTE;
            r_cfg.code_address  <= RST_CODE_BYTE;
            r_cfg.code_open     <= RST_CODE_BYTE;
            r_cfg.blind_ticks   <= RST_BLIND;
            r_cfg.timeout_ticks <= RST_TIMEOUT;
            r_cfg.one_width     <= RST_ONE;
            r_cfg.zero_width    <= RST_ZERO;
            r_cfg.gap_width     <= RST_GAP;
        end else if (w_wr) begin
            unique case (t_reg_idx'(i_cfg.data.index))
                REG_CODE_HEAD:    r_cfg.code_head     <= i_cfg.data.wdata[7:0];
                REG_CODE_ADDRESS: r_cfg.code_address  <= i_cfg.data.wdata[7:0];
                REG_CODE_OPEN:    r_cfg.code_open     <= i_cfg.data.wdata[7:0];
                REG_BLIND_TICKS:  r_cfg.blind_ticks   <= i_cfg.data.wdata;
                REG_TIMEOUT:      r_cfg.timeout_ticks <= i_cfg.data.wdata;
                REG_ONE_WIDTH:    r_cfg.one_width     <= i_cfg.data.wdata[7:0];
                REG_ZERO_WIDTH:   r_cfg.zero_width    <= i_cfg.data.wdata[7:0];
                REG_GAP_WIDTH:    r_cfg.gap_width     <= i_cfg.data.wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // A code byte write raises a registered reload request in the following cycle, once the new
    // byte is visible in the register set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_wr <= 1'b0;
        end else begin
            r_code_wr <= w_wr && (i_cfg.data.index == REG_CODE_HEAD ||
                                  i_cfg.data.index == REG_CODE_ADDRESS ||
                                  i_cfg.data.index == REG_CODE_OPEN);
        end
    end

    assign o_cfg     = r_cfg;
    assign o_code_wr = r_code_wr;

endmodule

FILE: rtl/core/clms_core.sv
// Sequencer state and its single-pass tick update: code sender, rotation timer, flags.
// Depends on clms_pkg; the top level supplies the registered tick and takes the result.
`timescale 1ns / 1ps

module clms_core #(
    parameter int CODE_BYTES = clms_pkg::CLMS_CODE_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  clms_pkg::t_in  i_item,
    input  clms_pkg::t_cfg i_cfg,
    input  logic           i_code_wr,
    output clms_pkg::t_out o_result
);
    import clms_pkg::*;

    localparam int CW = CODE_BYTES * 8;
    localparam int BW = (CODE_BYTES > 1) ? $clog2(CODE_BYTES) : 1;
    localparam logic [BW-1:0] LAST_BYTE = BW'(CODE_BYTES - 1);

    // State registers and next values.
    logic [15:0]   r_rot,      n_rot;
    logic [CW-1:0] r_code,     n_code;
    logic [7:0]    r_pulse,    n_pulse;
    logic          r_coding,   n_coding;
    logic [BW-1:0] r_byte_pos, n_byte_pos;
    logic [2:0]    r_bit_pos,  n_bit_pos;
    logic          r_opened,   n_opened;
    logic          r_line_a,   n_line_a;
    logic          r_line_b,   n_line_b;
    logic          r_blocked,  n_blocked;
    logic [15:0]   r_batt,     n_batt;

    logic [CW-1:0] w_code_load;
    logic [15:0]   w_rot_inc;
    logic          w_rot_end;
    logic [7:0]    w_pulse_inc;
    logic [7:0]    w_width;
    logic          w_power_off;
    logic          w_odone;
    logic          w_cdone;
    logic [1:0]    w_ann;
    logic          w_finished;

    // Code image, first byte at the top; positions past the third byte send zero.
    for (genvar gi = 0; gi < CODE_BYTES; gi++) begin : g_code
        if (gi == 0) begin : g_head
            assign w_code_load[CW-1-8*gi -: 8] = i_cfg.code_head;
        end else if (gi == 1) begin : g_addr
            assign w_code_load[CW-1-8*gi -: 8] = i_cfg.code_address;
        end else if (gi == 2) begin : g_open
            assign w_code_load[CW-1-8*gi -: 8] = i_cfg.code_open;
        end else begin : g_pad
            assign w_code_load[CW-1-8*gi -: 8] = 8'h00;
        end
    end

    // Saturating rotation counter and its stop condition.
    assign w_rot_inc = (r_rot == 16'hFFFF) ? r_rot : r_rot + 16'd1;
    assign w_rot_end = (w_rot_inc > i_cfg.blind_ticks) &&
                       ((w_rot_inc >= i_cfg.timeout_ticks) || i_item.overcurrent);

    // Pulse timer and the low width of the bit now on the line.
    assign w_pulse_inc = r_pulse + 8'd1;
    assign w_width     = r_code[CW-1] ? i_cfg.one_width : i_cfg.zero_width;

    // Tick update.
    always_comb begin
        n_rot       = r_rot;
        n_code      = r_code;
        n_pulse     = r_pulse;
        n_coding    = r_coding;
        n_byte_pos  = r_byte_pos;
        n_bit_pos   = r_bit_pos;
        n_opened    = r_opened;
        n_line_a    = r_line_a;
        n_line_b    = r_line_b;
        n_blocked   = r_blocked;
        n_batt      = r_batt;
        w_power_off = 1'b0;
        w_odone     = 1'b0;
        w_cdone     = 1'b0;
        w_ann       = ANN_NONE;
        w_finished  = 1'b0;

        if (i_step) begin
            // Open request: send the code, then rotate to open.
            if (i_item.key_on && i_item.id_ok && !r_opened) begin
                n_blocked = 1'b1;
                if (r_coding) begin
                    n_pulse = w_pulse_inc;
                    if (!r_line_b) begin
                        if (w_pulse_inc >= w_width) begin
                            n_pulse  = 8'd0;
                            n_line_b = 1'b1;
                            n_code   = r_code << 1;
                            if (r_bit_pos == 3'd7) begin
                                n_bit_pos = 3'd0;
                                if (r_byte_pos == LAST_BYTE) begin
                                    n_byte_pos = '0;
                                    n_coding   = 1'b0;
                                end else begin
                                    n_byte_pos = r_byte_pos + BW'(1);
                                end
                            end else begin
                                n_bit_pos = r_bit_pos + 3'd1;
                            end
                        end
                    end else if (w_pulse_inc >= i_cfg.gap_width) begin
                        n_pulse  = 8'd0;
                        n_line_b = 1'b0;
                    end
                end else begin
                    n_line_a = 1'b1;
                    n_line_b = 1'b0;
                    n_rot    = w_rot_inc;
                    if (w_rot_end) begin
                        n_rot      = 16'd0;
                        n_opened   = 1'b1;
                        n_blocked  = 1'b0;
                        n_line_b   = 1'b1;
                        n_code     = w_code_load;
                        n_coding   = 1'b1;
                        w_odone    = 1'b1;
                        w_finished = 1'b1;
                        if (!i_item.silent) begin
                            w_ann = ANN_OPENED;
                        end
                    end
                end
            end

            // Close request: rotate back with hall and controller power off.
            if (!w_finished && r_opened && (!i_item.key_on || i_item.auto_close)) begin
                n_blocked   = 1'b1;
                w_power_off = 1'b1;
                n_line_a    = 1'b0;
                n_line_b    = 1'b1;
                n_rot       = w_rot_inc;
                if (w_rot_end) begin
                    n_rot     = 16'd0;
                    n_opened  = 1'b0;
                    n_blocked = 1'b0;
                    n_line_a  = 1'b1;
                    n_batt    = i_item.battery_sample;
                    w_cdone   = 1'b1;
                    if (!i_item.silent) begin
                        w_ann = ANN_CLOSED;
                    end
                end
            end
        end else if (i_code_wr && r_coding && r_byte_pos == '0 && r_bit_pos == 3'd0 &&
                     r_pulse == 8'd0 && r_line_b) begin
            // A code write before any bit went out takes effect at once.
            n_code = w_code_load;
        end
    end

    // Control state; the code image resets to the reset code bytes, all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot      <= 16'd0;
            r_code     <= '0;
            r_pulse    <= 8'd0;
            r_coding   <= 1'b1;
            r_byte_pos <= '0;
            r_bit_pos  <= 3'd0;
            r_opened   <= 1'b0;
            r_line_a   <= 1'b1;
            r_line_b   <= 1'b1;
            r_blocked  <= 1'b0;
            r_batt     <= 16'd0;
        end else begin
            r_rot      <= n_rot;
            r_code     <= n_code;
            r_pulse    <= n_pulse;
            r_coding   <= n_coding;
            r_byte_pos <= n_byte_pos;
            r_bit_pos  <= n_bit_pos;
            r_opened   <= n_opened;
            r_line_a   <= n_line_a;
            r_line_b   <= n_line_b;
            r_blocked  <= n_blocked;
            r_batt     <= n_batt;
        end
    end

    // Result of this tick, taken from the updated state.
    always_comb begin
        o_result.motor_a         = n_line_a;
        o_result.motor_b         = n_line_b;
        o_result.block_buttons   = n_blocked;
        o_result.force_power_off = w_power_off;
        o_result.lock_open       = n_opened;
        o_result.open_done       = w_odone;
        o_result.close_done      = w_cdone;
        o_result.announce        = w_ann;
        o_result.battery_latched = n_batt;
    end

    // Line A is only low while closing, and then line B is high.
    a_close_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_line_a |-> (r_line_b && r_opened && r_blocked))
        else $error("line A low outside a close rotation");

    // Once the code is out, the code sender stands at its start.
    a_coder_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_coding |-> (r_pulse == 8'd0 && r_bit_pos == 3'd0 && r_byte_pos == '0))
        else $error("code sender not at rest after the last bit");

    // The rotation counter runs only after the code is sent or while closing.
    a_rot_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rot != 16'd0) |-> (!r_coding || r_opened))
        else $error("rotation counter running during code transmission");

endmodule

FILE: rtl/core/coded_lock_motor_sequencer.sv
// Top level of the coded lock motor sequencer: tick input register, result register, handshakes.
// Depends on clms_pkg, clms_stream_if, clms_cfg and clms_core.
//
// Usage:
//   i_in carries one request per 1 ms tick (key, identity, auto close, overcurrent,
//   silent, battery sample). o_out returns exactly one result per request: the two
//   motor bridge lines, button block, power off, lock state, done pulses, speech
//   request and the battery sample latched at the last close.
//   i_cfg writes one configuration register per request (index and data); it is
//   always ready. Writes must be made while no request is in flight; the block does not enforce it.
// Pipeline and throughput:
//   A request is taken into the input register, passed through the state update
//   once the result register is free or draining, and its result is registered and
//   shown valid. A new request is taken every cycle while o_out.ready stays high; the
//   state update is a single pass through the core between the input and result registers.
// Reset:
//   i_rst_n is synchronous and active low. It empties both registers, loads the
//   configuration defaults and puts the lock closed with both lines high.
// Stall:
//   While o_out.ready is low the result holds; one more request may still be taken
//   into the input register, after which i_in.ready drops until the result is taken.
`timescale 1ns / 1ps

module coded_lock_motor_sequencer #(
    parameter int CODE_BYTES = clms_pkg::CLMS_CODE_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    clms_stream_if.sink   i_cfg,
    clms_stream_if.sink   i_in,
    clms_stream_if.source o_out
);
    import clms_pkg::*;

    t_cfg w_cfg;
    logic w_code_wr;
    logic w_advance;
    t_out w_result;

    logic r_in_valid;
    t_in  r_in_data;
    logic r_out_valid;
    t_out r_out_data;

    // Configuration registers.
    clms_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_cfg     (w_cfg),
        .o_code_wr (w_code_wr)
    );

    // The registered request moves on when the result register is free or draining.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_data <= i_in.data;
        end
    end

    // State update.
    clms_core #(
        .CODE_BYTES (CODE_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_item    (r_in_data),
        .i_cfg     (w_cfg),
        .i_code_wr (w_code_wr),
        .o_result  (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= w_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Open and close never finish on the same tick.
    a_one_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data.open_done && r_out_data.close_done))
        else $error("open and close finished together");

    // A finish pulse agrees with the lock state it leaves behind.
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.open_done || r_out_data.close_done)) |->
        (r_out_data.lock_open == r_out_data.open_done && !r_out_data.block_buttons))
        else $error("done pulse does not match lock state");

    // Power is cut only on closing ticks, where line A is low unless the close ends.
    a_power_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.force_power_off) |->
        (!r_out_data.motor_a || r_out_data.close_done))
        else $error("power off outside a close rotation");

endmodule
